[sv/tcs_pkg.sv]
// Package for the triangle column span block.
// Shared widths and parameter defaults; no dependencies.
package tcs_pkg;

    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int COORD_INT_BITS_DEF  = 12;
    localparam int SLOPE_FRAC_BITS_DEF = 16;

    localparam int VTX_W = 16;
    localparam int COL_W = 12;
    localparam int ROW_W = 12;
    localparam int CLR_W = 8;

endpackage

[sv/triangle_column_span_top.sv]
// Top level of the triangle column span block.
// Uses tcs_pkg and two tcs_div_chain slope dividers.
//
// channel   dir  handshake          payload
// request   in   start & !busy      vertex_{a,b,c}_{x,y}, column, red/green/blue_in
// result    out  o_valid strobe     span_column, row_low, row_high, covered, colors
//
// One request per clock; busy is never raised.
// The pipeline is a select register, the divider cell row (one quotient bit
// per cell), then multiply, add and round stages.
// Reset clears the valid pipeline only. Results cannot be stalled.
module triangle_column_span_top
    import tcs_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int COORD_INT_BITS  = COORD_INT_BITS_DEF,
    parameter int SLOPE_FRAC_BITS = SLOPE_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [VTX_W-1:0] i_vertex_a_x,
    input  logic signed [VTX_W-1:0] i_vertex_a_y,
    input  logic signed [VTX_W-1:0] i_vertex_b_x,
    input  logic signed [VTX_W-1:0] i_vertex_b_y,
    input  logic signed [VTX_W-1:0] i_vertex_c_x,
    input  logic signed [VTX_W-1:0] i_vertex_c_y,
    input  logic signed [COL_W-1:0] i_column,
    input  logic [CLR_W-1:0]        i_red_in,
    input  logic [CLR_W-1:0]        i_green_in,
    input  logic [CLR_W-1:0]        i_blue_in,
    output logic                    o_valid,
    output logic signed [COL_W-1:0] o_span_column,
    output logic signed [ROW_W-1:0] o_row_low,
    output logic signed [ROW_W-1:0] o_row_high,
    output logic                    o_covered,
    output logic [CLR_W-1:0]        o_red_out,
    output logic [CLR_W-1:0]        o_green_out,
    output logic [CLR_W-1:0]        o_blue_out
);

    localparam int XW  = COL_W + COORD_FRAC_BITS;
    localparam int EW  = ((XW > VTX_W) ? XW : VTX_W) + 1;
    localparam int NW  = VTX_W + 1 + SLOPE_FRAC_BITS;
    localparam int QW  = NW + 1;
    localparam int PW  = QW + EW;
    localparam int HW  = PW + 1;
    localparam int SH  = COORD_FRAC_BITS + SLOPE_FRAC_BITS;
    localparam int LAT = NW + 4;

    localparam logic signed [HW-1:0] UNIT_M1 = HW'((64'sd1 <<< SH) - 64'sd1);
    localparam logic signed [HW-1:0] ROW_HI  = HW'((64'sd1 <<< (COORD_INT_BITS - 1)) - 64'sd1);
    localparam logic signed [HW-1:0] ROW_LO  = HW'(-(64'sd1 <<< (COORD_INT_BITS - 1)));

    typedef enum logic [1:0] {ROT_A, ROT_B, ROT_C} t_rot;

    typedef struct packed {
        logic                    hit;
        logic signed [COL_W-1:0] col;
        logic signed [EW-1:0]    x;
        logic signed [VTX_W-1:0] up_px;
        logic signed [VTX_W-1:0] up_py;
        logic signed [VTX_W-1:0] up_qx;
        logic signed [VTX_W-1:0] up_qy;
        logic signed [VTX_W-1:0] lo_px;
        logic signed [VTX_W-1:0] lo_py;
        logic signed [VTX_W-1:0] lo_qx;
        logic signed [VTX_W-1:0] lo_qy;
        logic [CLR_W-1:0]        red;
        logic [CLR_W-1:0]        green;
        logic [CLR_W-1:0]        blue;
    } t_sb;

    t_rot                    rot;
    logic signed [VTX_W-1:0] ax, ay, bx, by, cx, cy;
    logic signed [EW-1:0]    xa, xb, xc, xx;
    t_sb                     n_sb;
    t_sb                     r_sb [0:NW];
    logic                    r_vld [0:NW];

    assign busy = 1'b0;

    // leftmost vertex first, then pick upper and lower edges
    always_comb begin
        if (i_vertex_a_x <= i_vertex_b_x && i_vertex_a_x <= i_vertex_c_x) begin
            rot = ROT_A;
        end else if (i_vertex_b_x <= i_vertex_c_x && i_vertex_b_x <= i_vertex_a_x) begin
            rot = ROT_B;
        end else begin
            rot = ROT_C;
        end
        case (rot)
            ROT_A: begin
                ax = i_vertex_a_x; ay = i_vertex_a_y;
                bx = i_vertex_b_x; by = i_vertex_b_y;
                cx = i_vertex_c_x; cy = i_vertex_c_y;
            end
            ROT_B: begin
                ax = i_vertex_b_x; ay = i_vertex_b_y;
                bx = i_vertex_c_x; by = i_vertex_c_y;
                cx = i_vertex_a_x; cy = i_vertex_a_y;
            end
            default: begin
                ax = i_vertex_c_x; ay = i_vertex_c_y;
                bx = i_vertex_a_x; by = i_vertex_a_y;
                cx = i_vertex_b_x; cy = i_vertex_b_y;
            end
        endcase
        xa = EW'(ax);
        xb = EW'(bx);
        xc = EW'(cx);
        xx = EW'(XW'(i_column) <<< COORD_FRAC_BITS);

        n_sb       = '0;
        n_sb.col   = i_column;
        n_sb.x     = xx;
        n_sb.red   = i_red_in;
        n_sb.green = i_green_in;
        n_sb.blue  = i_blue_in;
        n_sb.up_px = ax; n_sb.up_py = ay; n_sb.up_qx = cx; n_sb.up_qy = cy;
        n_sb.lo_px = ax; n_sb.lo_py = ay; n_sb.lo_qx = bx; n_sb.lo_qy = by;

        if (bx < cx) begin
            if (ax == bx) begin
                n_sb.hit = (xx >= xb) && (xx <= xc);
                n_sb.lo_px = bx; n_sb.lo_py = by; n_sb.lo_qx = cx; n_sb.lo_qy = cy;
            end else if (xx >= xa && xx <= xb) begin
                n_sb.hit = 1'b1;
            end else begin
                n_sb.hit = (xx > xb) && (xx <= xc);
                n_sb.lo_px = bx; n_sb.lo_py = by; n_sb.lo_qx = cx; n_sb.lo_qy = cy;
            end
        end else if (ax == cx) begin
            n_sb.hit = (ax != bx) && (xx >= xa) && (xx <= xb);
            n_sb.up_px = cx; n_sb.up_py = cy; n_sb.up_qx = bx; n_sb.up_qy = by;
        end else if (cx == bx) begin
            n_sb.hit = (xx >= xa) && (xx <= xb);
        end else if (xx >= xa && xx <= xc) begin
            n_sb.hit = 1'b1;
        end else begin
            n_sb.hit = (xx > xc) && (xx <= xb);
            n_sb.up_px = cx; n_sb.up_py = cy; n_sb.up_qx = bx; n_sb.up_qy = by;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= n_sb;
        for (int k = 1; k <= NW; k++) begin
            r_sb[k] <= r_sb[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k <= NW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // divider operands: floor division uses |n| + d - 1 for negative n
    logic signed [VTX_W:0] up_dy, up_dx, lo_dy, lo_dx;
    logic [VTX_W:0]        up_ady, lo_ady;
    logic [NW-1:0]         up_num, lo_num;
    logic signed [QW-1:0]  up_quo, lo_quo;

    always_comb begin
        up_dy  = (VTX_W+1)'(r_sb[0].up_qy) - (VTX_W+1)'(r_sb[0].up_py);
        up_dx  = (VTX_W+1)'(r_sb[0].up_qx) - (VTX_W+1)'(r_sb[0].up_px);
        lo_dy  = (VTX_W+1)'(r_sb[0].lo_qy) - (VTX_W+1)'(r_sb[0].lo_py);
        lo_dx  = (VTX_W+1)'(r_sb[0].lo_qx) - (VTX_W+1)'(r_sb[0].lo_px);
        up_ady = up_dy[VTX_W] ? -up_dy : up_dy;
        lo_ady = lo_dy[VTX_W] ? -lo_dy : lo_dy;
        up_num = {1'b0, up_ady[VTX_W-1:0], {SLOPE_FRAC_BITS{1'b0}}}
               + (up_dy[VTX_W] ? NW'(up_dx[VTX_W-1:0] - 1'b1) : '0);
        lo_num = {1'b0, lo_ady[VTX_W-1:0], {SLOPE_FRAC_BITS{1'b0}}}
               + (lo_dy[VTX_W] ? NW'(lo_dx[VTX_W-1:0] - 1'b1) : '0);
    end

    tcs_div_chain #(.NW(NW)) u_div_up (
        .i_clk (i_clk),
        .i_num (up_num),
        .i_den (up_dx[VTX_W-1:0]),
        .i_neg (up_dy[VTX_W]),
        .o_quo (up_quo)
    );

    tcs_div_chain #(.NW(NW)) u_div_lo (
        .i_clk (i_clk),
        .i_num (lo_num),
        .i_den (lo_dx[VTX_W-1:0]),
        .i_neg (lo_dy[VTX_W]),
        .o_quo (lo_quo)
    );

    // slope times column offset, then add the edge's start row
    t_sb                  r_sbp, r_sbh;
    logic                 r_vp, r_vh;
    logic signed [EW-1:0] up_off, lo_off;
    logic signed [PW-1:0] r_p_up, r_p_lo;
    logic signed [HW-1:0] r_h_up, r_h_lo;

    assign up_off = r_sb[NW].x - EW'(r_sb[NW].up_px);
    assign lo_off = r_sb[NW].x - EW'(r_sb[NW].lo_px);

    always_ff @(posedge i_clk) begin
        r_p_up <= PW'(up_quo) * PW'(up_off);
        r_p_lo <= PW'(lo_quo) * PW'(lo_off);
        r_sbp  <= r_sb[NW];
        r_h_up <= (HW'(r_sbp.up_py) <<< SLOPE_FRAC_BITS) + HW'(r_p_up);
        r_h_lo <= (HW'(r_sbp.lo_py) <<< SLOPE_FRAC_BITS) + HW'(r_p_lo);
        r_sbh  <= r_sbp;
    end

    // round to rows, test for empty span, saturate
    logic signed [HW-1:0]    h_row, l_row, h_sat, l_sat;
    logic                    cov;
    logic                    r_valid, r_covered;
    logic signed [COL_W-1:0] r_col;
    logic signed [ROW_W-1:0] r_row_low, r_row_high;
    logic [CLR_W-1:0]        r_red, r_green, r_blue;

    always_comb begin
        h_row = r_h_up >>> SH;
        l_row = (r_h_lo + UNIT_M1) >>> SH;
        cov   = r_sbh.hit && (l_row <= h_row);
        h_sat = (h_row > ROW_HI) ? ROW_HI : ((h_row < ROW_LO) ? ROW_LO : h_row);
        l_sat = (l_row > ROW_HI) ? ROW_HI : ((l_row < ROW_LO) ? ROW_LO : l_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp    <= 1'b0;
            r_vh    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_vp    <= r_vld[NW];
            r_vh    <= r_vp;
            r_valid <= r_vh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col      <= r_sbh.col;
        r_covered  <= cov;
        r_row_low  <= cov ? l_sat[ROW_W-1:0] : '0;
        r_row_high <= cov ? h_sat[ROW_W-1:0] : '0;
        r_red      <= r_sbh.red;
        r_green    <= r_sbh.green;
        r_blue     <= r_sbh.blue;
    end

    assign o_valid       = r_valid;
    assign o_span_column = r_col;
    assign o_row_low     = r_row_low;
    assign o_row_high    = r_row_high;
    assign o_covered     = r_covered;
    assign o_red_out     = r_red;
    assign o_green_out   = r_green;
    assign o_blue_out    = r_blue;

    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without matching request");

    a_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_covered) |-> (o_row_low == '0 && o_row_high == '0))
        else $error("uncovered span carries nonzero rows");

    a_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_covered) |-> (o_row_low <= o_row_high || COORD_INT_BITS > ROW_W))
        else $error("covered span has low row above high row");

endmodule

[sv/tcs_div_cell.sv]
// One restoring-division cell: produces one quotient bit per cycle.
// Depends on nothing; chained by tcs_div_chain.
module tcs_div_cell #(
    parameter int NW = 33,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_quo,
    input  logic [DW-1:0] i_den,
    input  logic          i_neg,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_num,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_den,
    output logic          o_neg
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_num;
    logic [NW-1:0] n_quo;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic          r_neg;

    always_comb begin
        trial = {i_rem, i_num[NW-1]};
        ge    = (trial >= {1'b0, i_den});
        diff  = trial - {1'b0, i_den};
        n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        n_num = {i_num[NW-2:0], 1'b0};
        n_quo = {i_quo[NW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_num <= n_num;
        r_quo <= n_quo;
        r_den <= i_den;
        r_neg <= i_neg;
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;
    assign o_den = r_den;
    assign o_neg = r_neg;

endmodule

[sv/tcs_div_chain.sv]
// Pipelined floor divider built from a row of tcs_div_cell.
// Takes a magnitude already biased for floor rounding; depends on tcs_pkg.
module tcs_div_chain
    import tcs_pkg::*;
#(
    parameter int NW = 33
) (
    input  logic                i_clk,
    input  logic [NW-1:0]       i_num,
    input  logic [VTX_W-1:0]    i_den,
    input  logic                i_neg,
    output logic signed [NW:0]  o_quo
);

    logic [VTX_W-1:0] w_rem [0:NW];
    logic [NW-1:0]    w_num [0:NW];
    logic [NW-1:0]    w_quo [0:NW];
    logic [VTX_W-1:0] w_den [0:NW];
    logic             w_neg [0:NW];

    assign w_rem[0] = '0;
    assign w_num[0] = i_num;
    assign w_quo[0] = '0;
    assign w_den[0] = i_den;
    assign w_neg[0] = i_neg;

    for (genvar k = 0; k < NW; k++) begin : g_cell
        tcs_div_cell #(
            .NW (NW),
            .DW (VTX_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_rem (w_rem[k]),
            .i_num (w_num[k]),
            .i_quo (w_quo[k]),
            .i_den (w_den[k]),
            .i_neg (w_neg[k]),
            .o_rem (w_rem[k+1]),
            .o_num (w_num[k+1]),
            .o_quo (w_quo[k+1]),
            .o_den (w_den[k+1]),
            .o_neg (w_neg[k+1])
        );
    end

    assign o_quo = w_neg[NW] ? -$signed({1'b0, w_quo[NW]}) : $signed({1'b0, w_quo[NW]});

endmodule
